[hdl/tcw_pkg.sv]
// text console writer package: field widths, operation and register codes,
// and the command and status structs between the controller and the datapath
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int DATA_W      = 16;
    localparam int ROW_OUT_W   = 5;
    localparam int COL_OUT_W   = 7;
    localparam int POS_OUT_W   = 11;
    localparam int COLOR_W     = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK_CHAR = 2'd2;

    localparam logic [COLOR_W-1:0] FG_COLOR_RESET   = 4'd15;
    localparam logic [COLOR_W-1:0] BG_COLOR_RESET   = 4'd0;
    localparam logic [CHAR_W-1:0]  BLANK_CHAR_RESET = 8'd32;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;

    // controller -> datapath
    typedef struct packed {
        logic capture;       // latch the accepted request
        logic put_write;     // write the character cell at the cursor
        logic col_inc;       // advance the cursor column
        logic new_row;       // move to column 0 of the next row
        logic col_zero;      // column 0 on the bottom row (scroll case)
        logic set_scrolled;  // flag the result as scrolled
        logic sweep_start;   // sweep counter to cell 0
        logic fill_start;    // sweep counter to the start of the bottom row
        logic copy_step;     // read one cell a row below, write it one row up
        logic blank_step;    // write one blank cell at the sweep counter
        logic home;          // cursor and last row to zero
        logic read_issue;    // read the requested cell
        logic finish;        // load the output register
    } tcw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic is_newline;
        logic col_last;
        logic row_last;
        logic idx_ok;
        logic copy_last;
        logic sweep_last;
        logic out_free;
    } tcw_status_t;

endpackage

[hdl/tcw_ctrl.sv]
// text console writer controller: one-hot state machine that sequences a put,
// a scroll, a clear or a read and issues commands to the datapath
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  tcw_status_t st,
    output tcw_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_COPY   = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_FILL   = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   line_break;

    assign in_stall   = (state_reg != S_IDLE);
    assign line_break = st.is_newline || st.col_last;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (st.op)
                    OP_PUT:
                    begin
                        cmd.put_write = !st.is_newline;
                        if (line_break && st.row_last)
                        begin
                            cmd.col_zero     = 1'b1;
                            cmd.set_scrolled = 1'b1;
                            cmd.sweep_start  = 1'b1;
                            state_next       = S_COPY;
                        end
                        else if (line_break)
                        begin
                            cmd.new_row = 1'b1;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cmd.col_inc = 1'b1;
                            state_next  = S_FINISH;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    OP_READ:
                    begin
                        cmd.read_issue = st.idx_ok;
                        state_next     = S_FINISH;
                    end
                    OP_NONE:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (st.copy_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last copied cell is written back this cycle
                cmd.fill_start = 1'b1;
                state_next     = S_FILL;
            end
            S_FILL:
            begin
                cmd.blank_step = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_CLEAR:
            begin
                cmd.blank_step = 1'b1;
                if (st.sweep_last)
                begin
                    cmd.home   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/tcw_dp.sv]
// text console writer datapath: screen store, cursor and colour registers,
// sweep counter for scroll and clear, and the output register
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_dp
    import tcw_pkg::*;
#(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [OP_W-1:0]        op,
    input  logic [CHAR_W-1:0]      char_code,
    input  logic [INDEX_W-1:0]     cell_index,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [DATA_W-1:0]      cell_data,
    output logic [ROW_OUT_W-1:0]   cursor_row,
    output logic [COL_OUT_W-1:0]   cursor_col,
    output logic [POS_OUT_W-1:0]   cursor_pos,
    output logic [ROW_OUT_W-1:0]   last_line,
    output logic                   scrolled,
    input  tcw_cmd_t               cmd,
    output tcw_status_t            st
);

    localparam int NCELLS = WIDTH * HEIGHT;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(HEIGHT);
    localparam int CW     = $clog2(WIDTH);

    localparam logic [AW-1:0] ROW_STEP   = AW'(WIDTH);
    localparam logic [AW-1:0] COPY_LAST  = AW'(NCELLS - WIDTH - 1);
    localparam logic [AW-1:0] FILL_FIRST = AW'(NCELLS - WIDTH);
    localparam logic [AW-1:0] CELL_LAST  = AW'(NCELLS - 1);
    localparam logic [RW-1:0] ROW_LAST   = RW'(HEIGHT - 1);
    localparam logic [CW-1:0] COL_LAST   = CW'(WIDTH - 1);

    logic [DATA_W-1:0] screen_mem [NCELLS];

    logic [OP_W-1:0]    op_reg;
    logic [CHAR_W-1:0]  ch_reg;
    logic [INDEX_W-1:0] idx_reg;

    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [CHAR_W-1:0]  blank_reg;

    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [AW-1:0] base_reg;
    logic [RW-1:0] last_row_reg;
    logic          scrolled_reg;

    logic [AW-1:0]     cnt_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic [DATA_W-1:0] rdata_reg;

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    cell_data_reg;
    logic [ROW_OUT_W-1:0] cursor_row_reg;
    logic [COL_OUT_W-1:0] cursor_col_reg;
    logic [POS_OUT_W-1:0] cursor_pos_reg;
    logic [ROW_OUT_W-1:0] last_line_reg;
    logic                 scrolled_out_reg;

    logic [31:0]       idx_ext;
    logic [31:0]       row_ext;
    logic [31:0]       col_ext;
    logic [31:0]       pos_ext;
    logic [31:0]       last_ext;
    logic              idx_ok;
    logic [CHAR_W-1:0] put_char;
    logic [DATA_W-1:0] blank_cell;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    assign idx_ext  = 32'(idx_reg);
    assign idx_ok   = (idx_ext < 32'(NCELLS));
    assign row_ext  = 32'(row_reg);
    assign col_ext  = 32'(col_reg);
    assign pos_ext  = 32'(base_reg + AW'(col_reg));
    assign last_ext = 32'(last_row_reg);

    assign put_char   = (ch_reg == CHAR_NUL) ? blank_reg : ch_reg;
    assign blank_cell = {bg_reg, fg_reg, blank_reg};

    // status
    always_comb
    begin
        st.op         = op_t'(op_reg);
        st.is_newline = (ch_reg == CHAR_NEWLINE);
        st.col_last   = (col_reg == COL_LAST);
        st.row_last   = (row_reg == ROW_LAST);
        st.idx_ok     = idx_ok;
        st.copy_last  = (cnt_reg == COPY_LAST);
        st.sweep_last = (cnt_reg == CELL_LAST);
        st.out_free   = !out_valid_reg || !out_stall;
    end

    // store ports: pending copy write has priority, the controller never
    // overlaps it with another write
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = blank_cell;
        if (pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = rdata_reg;
        end
        else if (cmd.put_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = base_reg + AW'(col_reg);
            mem_wdata = {bg_reg, fg_reg, put_char};
        end
        else if (cmd.blank_step)
        begin
            mem_we = 1'b1;
        end
    end

    assign mem_re    = cmd.copy_step || cmd.read_issue;
    assign mem_raddr = cmd.copy_step ? (cnt_reg + ROW_STEP) : idx_ext[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    // request capture and copy bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            ch_reg  <= char_code;
            idx_reg <= cell_index;
        end
        pend_addr_reg <= cnt_reg;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg    <= FG_COLOR_RESET;
            bg_reg    <= BG_COLOR_RESET;
            blank_reg <= BLANK_CHAR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FG_COLOR:   fg_reg    <= cfg_data[COLOR_W-1:0];
                REG_BG_COLOR:   bg_reg    <= cfg_data[COLOR_W-1:0];
                REG_BLANK_CHAR: blank_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // cursor, sweep counter and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            last_row_reg <= '0;
            scrolled_reg <= 1'b0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.copy_step;
            if (cmd.capture)
            begin
                scrolled_reg <= 1'b0;
            end
            else if (cmd.set_scrolled)
            begin
                scrolled_reg <= 1'b1;
            end
            if (cmd.home)
            begin
                row_reg      <= '0;
                col_reg      <= '0;
                base_reg     <= '0;
                last_row_reg <= '0;
            end
            else if (cmd.new_row)
            begin
                row_reg  <= row_reg + RW'(1);
                col_reg  <= '0;
                base_reg <= base_reg + ROW_STEP;
                if (last_row_reg != ROW_LAST)
                begin
                    last_row_reg <= last_row_reg + RW'(1);
                end
            end
            else if (cmd.col_zero)
            begin
                col_reg <= '0;
            end
            else if (cmd.col_inc)
            begin
                col_reg <= col_reg + CW'(1);
            end
            if (cmd.sweep_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.fill_start)
            begin
                cnt_reg <= FILL_FIRST;
            end
            else if (cmd.copy_step || cmd.blank_step)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            cell_data_reg    <= (op_t'(op_reg) == OP_READ && idx_ok) ? rdata_reg : '0;
            cursor_row_reg   <= row_ext[ROW_OUT_W-1:0];
            cursor_col_reg   <= col_ext[COL_OUT_W-1:0];
            cursor_pos_reg   <= pos_ext[POS_OUT_W-1:0];
            last_line_reg    <= last_ext[ROW_OUT_W-1:0];
            scrolled_out_reg <= scrolled_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_data  = cell_data_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_pos = cursor_pos_reg;
    assign last_line  = last_line_reg;
    assign scrolled   = scrolled_out_reg;

endmodule

[hdl/text_console_writer.sv]
// text console writer top level: controller and datapath joined by command
// and status structs
// depends on tcw_pkg, tcw_ctrl, tcw_dp
`timescale 1ns / 1ps

//  channel   handshake              payload
//  in        in_valid / in_stall    op, char_code, cell_index
//  out       out_valid / out_stall  cell_data, cursor_row, cursor_col,
//                                   cursor_pos, last_line, scrolled
//  cfg       cfg_we                 cfg_index, cfg_data
//
//  one request at a time; a put, a read or a no-op passes the decode and finish
//  steps before it reaches the output register; a new request is taken only
//  once the block is back in idle
//  a put that scrolls goes on to copy: the single-port-write screen store moves
//  one cell a cycle up, then blanks the bottom row
//  a clear sweeps the whole screen, one blank cell written per cycle
//  in_stall is low only in idle, so a new request is taken while a result
//  still waits in the output register; out_stall holds the result in place
//  rst_n clears the cursor and control state and sets the colours to their reset values; the screen store has
//  no reset and holds nothing defined until written or cleared

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [OP_W-1:0]        op,
    input  logic [CHAR_W-1:0]      char_code,
    input  logic [INDEX_W-1:0]     cell_index,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [DATA_W-1:0]      cell_data,
    output logic [ROW_OUT_W-1:0]   cursor_row,
    output logic [COL_OUT_W-1:0]   cursor_col,
    output logic [POS_OUT_W-1:0]   cursor_pos,
    output logic [ROW_OUT_W-1:0]   last_line,
    output logic                   scrolled
);

    // commands from the sequencer, status back from the datapath
    tcw_cmd_t    cmd;
    tcw_status_t st;

    // sequencer: decode, scroll copy and fill, clear sweep, result hand-off
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // screen store, cursor tracking and the output register
    tcw_dp #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .cell_data  (cell_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cursor_pos (cursor_pos),
        .last_line  (last_line),
        .scrolled   (scrolled),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

[hdl/tcw_checker.sv]
// text console writer port checker and its bind to the top level
// depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 25
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [DATA_W-1:0]    cell_data,
    input logic [ROW_OUT_W-1:0] cursor_row,
    input logic [COL_OUT_W-1:0] cursor_col,
    input logic [POS_OUT_W-1:0] cursor_pos,
    input logic [ROW_OUT_W-1:0] last_line,
    input logic                 scrolled
);

    localparam logic [ROW_OUT_W-1:0] ROW_LAST = ROW_OUT_W'(HEIGHT - 1);
    localparam bit FITS = (HEIGHT <= 32) && (WIDTH <= 128);

    logic [31:0] pos_calc;
    assign pos_calc = 32'(cursor_row) * 32'(WIDTH) + 32'(cursor_col);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cell_data) && $stable(cursor_pos)
                                   && $stable(last_line) && $stable(scrolled))
        else $error("stalled result changed");

    // linear position agrees with row and column
    a_pos_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && FITS |-> cursor_pos == pos_calc[POS_OUT_W-1:0])
        else $error("cursor position does not match row and column");

    // a scroll leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> cursor_col == '0 && cursor_row == ROW_LAST)
        else $error("scroll left cursor off the bottom row start");

endmodule

bind text_console_writer tcw_checker #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
) u_tcw_checker (.*);

[tb/tb_top.sv]
// self-checking testbench for text_console_writer: directed and random put,
// clear, read and no-op requests, checked against an in-bench screen model
// depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int WIDTH  = 80;
    localparam int HEIGHT = 25;
    localparam int NCELLS = WIDTH * HEIGHT;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    // register index that decodes to nothing; writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // request budget of the random phases and how many phases share it
    localparam int RANDOM_REQUESTS = 1730;
    localparam int RANDOM_PHASES   = 8;

    // cycles after the last result before the block counts as idle
    localparam int SETTLE_CYCLES = 8;

    // a scroll or clear walks all cells, plus the longest gap and stall
    localparam int WATCHDOG_LIMIT = 20000;

    // at most this many mismatch lines are printed, all are counted
    localparam int REPORT_LINES = 40;

    // what one result should carry
    typedef struct packed {
        logic [DATA_W-1:0]    data;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [POS_OUT_W-1:0] pos;
        logic [ROW_OUT_W-1:0] last;
        logic                 scroll;
    } cursor_report_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // block inputs, all known from time zero
    logic                   cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic [OP_W-1:0]        op         = OP_PUT;
    logic [CHAR_W-1:0]      char_code  = '0;
    logic [INDEX_W-1:0]     cell_index = '0;
    logic                   out_stall  = 1'b0;

    // block outputs
    logic                 in_stall;
    logic                 out_valid;
    logic [DATA_W-1:0]    cell_data;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [POS_OUT_W-1:0] cursor_pos;
    logic [ROW_OUT_W-1:0] last_line;
    logic                 scrolled;

    text_console_writer #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_data  (cell_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cursor_pos (cursor_pos),
        .last_line  (last_line),
        .scrolled   (scrolled)
    );

    // screen model: cell contents, which cells hold defined data, cursor
    // and the colour registers as the block should see them
    logic [DATA_W-1:0] shadow_cell [NCELLS];
    bit                cell_known  [NCELLS];
    int                cur_row   = 0;
    int                cur_col   = 0;
    int                tail_row  = 0;
    logic [COLOR_W-1:0] ink_fg    = FG_COLOR_RESET;
    logic [COLOR_W-1:0] ink_bg    = BG_COLOR_RESET;
    logic [CHAR_W-1:0]  fill_char = BLANK_CHAR_RESET;

    // results still owed by the block, oldest first
    cursor_report_t pending_status [$];

    // run bookkeeping
    bit throttle_on    = 1'b1;
    int sent_count     = 0;
    int checked_count  = 0;
    int read_count     = 0;
    int clear_count    = 0;
    int scroll_seen    = 0;
    int settings_used  = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;

    // ------------------------------------------------------------------
    // screen model
    // ------------------------------------------------------------------

    // cursor to column 0 of the next row; on the bottom row the screen
    // moves up one row and a blank row comes in, returns 1 in that case
    function automatic bit line_feed();
        int i;
        cur_col = 0;
        if (cur_row == HEIGHT - 1)
        begin
            for (i = 0; i < NCELLS - WIDTH; i++)
            begin
                shadow_cell[i] = shadow_cell[i + WIDTH];
                cell_known[i]  = cell_known[i + WIDTH];
            end
            for (i = NCELLS - WIDTH; i < NCELLS; i++)
            begin
                shadow_cell[i] = {ink_bg, ink_fg, fill_char};
                cell_known[i]  = 1'b1;
            end
            return 1'b1;
        end
        cur_row++;
        // last used row stops at the bottom
        if (tail_row < HEIGHT - 1)
            tail_row++;
        return 1'b0;
    endfunction

    // apply one accepted request to the model and return what the block
    // should report for it
    function automatic cursor_report_t console_step(op_t kind, logic [CHAR_W-1:0] ch,
                                                    logic [INDEX_W-1:0] idx);
        cursor_report_t r;
        logic [CHAR_W-1:0] glyph;
        int i;
        r = '0;
        case (kind)
            OP_PUT:
            begin
                if (ch == CHAR_NEWLINE)
                begin
                    // newline writes nothing
                    r.scroll = line_feed();
                end
                else
                begin
                    // NUL stands for the blank character
                    glyph = (ch == CHAR_NUL) ? fill_char : ch;
                    shadow_cell[cur_row * WIDTH + cur_col] = {ink_bg, ink_fg, glyph};
                    cell_known[cur_row * WIDTH + cur_col]  = 1'b1;
                    cur_col++;
                    // wrap past the last column, scrolling on the bottom row
                    if (cur_col >= WIDTH)
                        r.scroll = line_feed();
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < NCELLS; i++)
                begin
                    shadow_cell[i] = {ink_bg, ink_fg, fill_char};
                    cell_known[i]  = 1'b1;
                end
                cur_row  = 0;
                cur_col  = 0;
                tail_row = 0;
            end
            OP_READ:
            begin
                // an index beyond the screen reads zero
                if (idx < NCELLS)
                    r.data = shadow_cell[idx];
            end
            default: ;  // no-op code just reports the cursor
        endcase
        r.row  = ROW_OUT_W'(cur_row);
        r.col  = COL_OUT_W'(cur_col);
        r.pos  = POS_OUT_W'(cur_row * WIDTH + cur_col);
        r.last = ROW_OUT_W'(tail_row);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // idle length: mostly short, now and then long
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // any character except newline, so text runs reach the line end
    function automatic logic [CHAR_W-1:0] text_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (c == CHAR_NEWLINE);
        return c;
    endfunction

    function automatic logic [INDEX_W-1:0] any_index();
        return INDEX_W'($urandom_range(0, INDEX_MAX));
    endfunction

    // a read address that never touches an undefined cell: mostly just
    // behind the cursor, else anywhere on screen, a few past the end
    function automatic logic [INDEX_W-1:0] pick_read_index();
        int r;
        int pos;
        int tries;
        r = $urandom_range(0, 99);
        if (r < 5)
            return INDEX_W'($urandom_range(NCELLS, INDEX_MAX));
        if (r < 55)
        begin
            pos = cur_row * WIDTH + cur_col - $urandom_range(1, 2 * WIDTH);
            if (pos >= 0 && cell_known[pos])
                return INDEX_W'(pos);
        end
        for (tries = 0; tries < 64; tries++)
        begin
            pos = $urandom_range(0, NCELLS - 1);
            if (cell_known[pos])
                return INDEX_W'(pos);
        end
        return INDEX_W'($urandom_range(NCELLS, INDEX_MAX));
    endfunction

    // ------------------------------------------------------------------
    // request driver, register writes, idle wait
    // ------------------------------------------------------------------

    // send one request and log its expected result once it is taken;
    // in_valid stays high on return so a back-to-back request needs no
    // second assignment in the same step
    task automatic issue_request(input op_t kind, input logic [CHAR_W-1:0] ch,
                                 input logic [INDEX_W-1:0] idx);
        int gap;
        gap = (throttle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= kind;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // taken at this edge
        pending_status.push_back(console_step(kind, ch, idx));
        sent_count++;
        if (kind == OP_READ)
            read_count++;
        if (kind == OP_CLEAR)
            clear_count++;
    endtask

    // drop valid, wait for every owed result and for the block to go idle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        while (in_stall)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three configuration registers plus a stray write to the unused
    // index, back to back; only called while the block is idle
    task automatic program_colors(input logic [CFG_DATA_W-1:0] fg_raw,
                                  input logic [CFG_DATA_W-1:0] bg_raw,
                                  input logic [CFG_DATA_W-1:0] blank_raw);
        logic [CFG_DATA_W-1:0] stray;
        stray = CFG_DATA_W'($urandom_range(0, 255));
        cfg_we    <= 1'b1;
        cfg_index <= REG_FG_COLOR;
        cfg_data  <= fg_raw;
        @(posedge clk);
        cfg_index <= REG_BG_COLOR;
        cfg_data  <= bg_raw;
        @(posedge clk);
        cfg_index <= REG_BLANK_CHAR;
        cfg_data  <= blank_raw;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= stray;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // colours keep only their low nibble
        ink_fg    = fg_raw[COLOR_W-1:0];
        ink_bg    = bg_raw[COLOR_W-1:0];
        fill_char = blank_raw;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, checker, watchdog
    // ------------------------------------------------------------------

    // out_stall bursts, off entirely while throttling is off
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (throttle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left = gap_length() - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("mismatch at %0t on result %0d, %s: got %0h, want %0h",
                     $realtime, checked_count, what, got, want);
    endtask

    // compare each taken result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        cursor_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                flag_mismatch("result with no request owed", 32'(cell_data), 0);
            end
            else
            begin
                want = pending_status.pop_front();
                if (cell_data !== want.data)
                    flag_mismatch("cell_data", 32'(cell_data), 32'(want.data));
                if (cursor_row !== want.row)
                    flag_mismatch("cursor_row", 32'(cursor_row), 32'(want.row));
                if (cursor_col !== want.col)
                    flag_mismatch("cursor_col", 32'(cursor_col), 32'(want.col));
                if (cursor_pos !== want.pos)
                    flag_mismatch("cursor_pos", 32'(cursor_pos), 32'(want.pos));
                if (last_line !== want.last)
                    flag_mismatch("last_line", 32'(last_line), 32'(want.last));
                if (scrolled !== want.scroll)
                    flag_mismatch("scrolled", 32'(scrolled), 32'(want.scroll));
                if (scrolled === 1'b1)
                    scroll_seen++;
                checked_count++;
            end
        end
    end

    // ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request or result moved in %0d cycles, %0d results owed",
                     idle_cycles, pending_status.size());
            $display("tb_top NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset colours: character extremes, NUL as blank, read-back of the
    // cells just written, reads past the screen end and the no-op code
    task automatic test_reset_defaults();
        int k;
        issue_request(OP_PUT, 8'h41, any_index());
        issue_request(OP_PUT, CHAR_NUL, any_index());
        issue_request(OP_PUT, 8'hFF, any_index());
        issue_request(OP_PUT, 8'h80, any_index());
        issue_request(OP_PUT, 8'h01, any_index());
        issue_request(OP_PUT, 8'h7F, INDEX_MAX);
        for (k = 0; k < 6; k++)
            issue_request(OP_READ, 8'hFF, INDEX_W'(k));
        issue_request(OP_READ, 8'h00, INDEX_MAX);
        issue_request(OP_READ, 8'h00, INDEX_W'(NCELLS));
        issue_request(OP_NONE, 8'hFF, INDEX_MAX);
        issue_request(OP_PUT, CHAR_NEWLINE, any_index());
        issue_request(OP_NONE, 8'h00, '0);
    endtask

    // clear fills every cell with blanks and homes the cursor
    task automatic test_clear_screen();
        issue_request(OP_CLEAR, 8'hFF, INDEX_MAX);
        issue_request(OP_READ, 8'h00, '0);
        issue_request(OP_READ, 8'h00, INDEX_W'(NCELLS - 1));
        issue_request(OP_READ, 8'h00, INDEX_W'(NCELLS / 2));
        issue_request(OP_PUT, 8'h78, any_index());
        issue_request(OP_READ, 8'h00, '0);
    endtask

    // walk down to the bottom row, fill it so the wrap scrolls, then a
    // newline on the bottom row scrolls again; last_line must hold
    task automatic test_line_end();
        int k;
        while (cur_row < HEIGHT - 1)
            issue_request(OP_PUT, CHAR_NEWLINE, any_index());
        while (cur_col < WIDTH - 1)
            issue_request(OP_PUT, text_char(), any_index());
        issue_request(OP_PUT, text_char(), any_index());
        issue_request(OP_PUT, CHAR_NEWLINE, any_index());
        for (k = 0; k < 3; k++)
        begin
            issue_request(OP_READ, 8'h00, INDEX_W'((HEIGHT - 3) * WIDTH + k));
            issue_request(OP_READ, 8'h00, INDEX_W'((HEIGHT - 1) * WIDTH + k));
        end
        issue_request(OP_READ, 8'h00, '0);
    endtask

    // colour and blank extremes, with out-of-width register data
    task automatic test_color_extremes();
        logic [CFG_DATA_W-1:0] fg_set    [3];
        logic [CFG_DATA_W-1:0] bg_set    [3];
        logic [CFG_DATA_W-1:0] blank_set [3];
        int k;
        fg_set    = '{8'h00, 8'hFF, 8'hA5};
        bg_set    = '{8'h00, 8'hFF, 8'h5A};
        blank_set = '{8'h00, 8'hFF, 8'h2E};
        for (k = 0; k < 3; k++)
        begin
            wait_idle();
            program_colors(fg_set[k], bg_set[k], blank_set[k]);
            issue_request(OP_PUT, CHAR_NUL, any_index());
            issue_request(OP_PUT, 8'hFF, any_index());
            issue_request(OP_READ, 8'h00, INDEX_W'(cur_row * WIDTH + cur_col - 2));
            issue_request(OP_READ, 8'h00, INDEX_W'(cur_row * WIDTH + cur_col - 1));
            issue_request(OP_CLEAR, 8'h00, any_index());
            issue_request(OP_READ, 8'h00, pick_read_index());
            issue_request(OP_PUT, CHAR_NEWLINE, any_index());
            issue_request(OP_PUT, CHAR_NUL, any_index());
            issue_request(OP_READ, 8'h00, INDEX_W'(cur_row * WIDTH));
        end
    endtask

    // bursts: text runs that wrap, newline runs that push to the bottom
    // and scroll, reads behind the cursor, and the odd clear or no-op
    task automatic random_burst_run(input int budget);
        int left;
        int run;
        int pick;
        int k;
        left = budget;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                run = $urandom_range(1, 100);
            else if (pick < 65)
                run = $urandom_range(1, 6);
            else if (pick < 88)
                run = $urandom_range(1, 4);
            else
                run = 1;
            if (run > left)
                run = left;
            for (k = 0; k < run; k++)
            begin
                if (pick < 45)
                    issue_request(OP_PUT, text_char(), any_index());
                else if (pick < 65)
                    issue_request(OP_PUT, CHAR_NEWLINE, any_index());
                else if (pick < 88)
                    issue_request(OP_READ, CHAR_W'($urandom_range(0, 255)),
                                  pick_read_index());
                else if (pick < 95)
                    issue_request(OP_NONE, CHAR_W'($urandom_range(0, 255)), any_index());
                else if (pick < 97)
                    issue_request(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), any_index());
                else
                    issue_request(OP_PUT, CHAR_NUL, any_index());
            end
            left -= run;
        end
    endtask

    // random phases, each under its own register setting; two phases run
    // with no gaps and no stalls at all
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            throttle_on = (phase != 3 && phase != 6);
            case (phase % 4)
                1:       program_colors(8'hFF, 8'hFF, 8'hFF);
                2:       program_colors(8'h00, 8'h00, 8'h00);
                default: program_colors(CFG_DATA_W'($urandom_range(0, 255)),
                                        CFG_DATA_W'($urandom_range(0, 255)),
                                        CFG_DATA_W'($urandom_range(0, 255)));
            endcase
            random_burst_run(RANDOM_REQUESTS / RANDOM_PHASES);
        end
        throttle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        // reset once, asynchronously asserted from time zero
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_clear_screen();
        test_line_end();
        test_color_extremes();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d requests (%0d reads, %0d clears), checked %0d results, %0d scrolls",
                 sent_count, read_count, clear_count, checked_count, scroll_seen);
        $display("colour settings applied: %0d, mismatches: %0d",
                 settings_used, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
